### design/block_id_interning_table_macros.svh
// ----------------------------------------------------------------------------
// Block ID interning table: assertion macros
// Shared concurrent checks, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_ID_INTERNING_TABLE_MACROS_SVH
`define BLOCK_ID_INTERNING_TABLE_MACROS_SVH

// condition must hold at every edge out of reset
`define BIDT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("bidt: invariant violated");

// consequence must hold in the same cycle as the trigger
`define BIDT_IMPLY(lbl, clk, rst_n, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error("bidt: implication violated");

// consequence must hold in the cycle after the trigger
`define BIDT_NEXT(lbl, clk, rst_n, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("bidt: next-cycle implication violated");

`endif

### design/bidt_pkg.sv
// ----------------------------------------------------------------------------
// Block ID interning table package
// Request/response word types, request codes and sizing constants.
// ----------------------------------------------------------------------------
package bidt_pkg;

	localparam int unsigned MAX_SLOTS       = 8;
	localparam int unsigned MAX_CELLS       = 1024;
	localparam int unsigned TILES_ACROSS    = 32;
	localparam int unsigned TILES_DOWN      = 32;
	localparam int unsigned TILES_PER_BLOCK = TILES_ACROSS * TILES_DOWN;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_RECORD = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [9:0]  cell_index;
		logic [15:0] land_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  block_slot;
		logic        was_new;
		logic        overflow;
		logic [15:0] slot_land_id;
		logic [12:0] tile_base;
		logic [3:0]  used_slots;
	} rsp_t;

endpackage

### design/bidt_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface bidt_req_if;
	logic          valid;
	logic          ready;
	bidt_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/bidt_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
interface bidt_rsp_if;
	logic          valid;
	logic          ready;
	bidt_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/bidt_slot_table.sv
// ----------------------------------------------------------------------------
// Slot table
// ID memory with one registered read port and the shared ID comparator.
// ----------------------------------------------------------------------------
module bidt_slot_table #(
	parameter int unsigned MAX_SLOTS = bidt_pkg::MAX_SLOTS,
	localparam int unsigned SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_addr,
	input  logic [15:0]       wr_data,
	input  logic [15:0]       key,
	output logic [15:0]       rd_data,
	output logic              hit
);

	logic [15:0] mem [MAX_SLOTS];
	logic [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign hit     = (rd_data_q == key);

endmodule

### design/block_id_interning_table.sv
// ----------------------------------------------------------------------------
// Block ID interning table
// Interns 16-bit land IDs of grid cells into a small slot table.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request word: clear the table, record a cell's land ID,
//   or look up a cell. rsp returns exactly one word per request.
//   A record scans the slots in use one per cycle through a single compare
//   unit fed by the registered read port of the slot table: a hit in slot j
//   ends the scan there, while a miss or an overflow (a full table of 8)
//   scans every slot in use. A lookup reads the cell map, then the slot table.
//   Clear, unknown codes and out-of-range lookups load their result on
//   acceptance, with no scan or table read.
//   req.ready is high only while no request is in progress; the next request
//   is accepted in the cycle after the result loads into the output register,
//   so a new request is taken only once the last one is through.
//   rsp has an output register: a new request is accepted while the prior
//   response waits; a finished result holds until rsp frees up.
//   Reset empties the table (slot count zero) and drops any pending word;
//   the ID table and cell map keep their contents, no clearing pass.
// ----------------------------------------------------------------------------
`include "block_id_interning_table_macros.svh"

module block_id_interning_table #(
	parameter int unsigned MAX_SLOTS = bidt_pkg::MAX_SLOTS,
	parameter int unsigned MAX_CELLS = bidt_pkg::MAX_CELLS
) (
	input  logic          clk,
	input  logic          arst_n,
	bidt_req_if.sink      req,
	bidt_rsp_if.source    rsp
);

	localparam int unsigned SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int unsigned CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int unsigned TPB    = bidt_pkg::TILES_PER_BLOCK;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_MAP  = 3'd2;
	localparam logic [2:0] S_LKID = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  idx_q;
	logic              cmp_vld_s1;
	logic [SLOT_W-1:0] cmp_idx_s1;
	logic [9:0]        cell_q;
	logic [15:0]       id_q;
	logic              cell_ok_q;
	bidt_pkg::rsp_t    res_q, res_d;
	logic              res_ld;
	bidt_pkg::rsp_t    out_q;
	logic              out_vld_q;
	logic              out_ld;

	logic              acc;
	logic              in_cell_ok;
	logic              scan_issue, scan_hit, scan_miss, full;
	logic              tbl_re, tbl_we, tbl_hit;
	logic [SLOT_W-1:0] tbl_ra;
	logic [15:0]       tbl_rd;
	logic              map_re, map_we;
	logic [SLOT_W-1:0] map_mem [MAX_CELLS];
	logic [SLOT_W-1:0] map_rd_q;
	logic [SLOT_W-1:0] fin_slot;

	assign req.ready  = (state_q == S_IDLE);
	assign acc        = req.valid && req.ready;
	assign in_cell_ok = (32'(req.data.cell_index) < MAX_CELLS);

	assign full       = (cnt_q == CNT_W'(MAX_SLOTS));
	assign scan_issue = (state_q == S_SCAN) && (idx_q != cnt_q);
	assign scan_hit   = (state_q == S_SCAN) && cmp_vld_s1 && tbl_hit;
	assign scan_miss  = (state_q == S_SCAN) && !cmp_vld_s1 && (idx_q == cnt_q);

	assign tbl_re = scan_issue || (state_q == S_MAP);
	assign tbl_ra = (state_q == S_MAP) ? map_rd_q : idx_q[SLOT_W-1:0];
	assign tbl_we = scan_miss && !full;

	assign map_re = acc && (req.data.req_type == bidt_pkg::REQ_LOOKUP) && in_cell_ok;
	assign map_we = (scan_hit || (scan_miss && !full)) && cell_ok_q;

	assign fin_slot = scan_hit ? cmp_idx_s1 : cnt_q[SLOT_W-1:0];

	bidt_slot_table #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_slot_table (
		.clk     (clk),
		.rd_en   (tbl_re),
		.rd_addr (tbl_ra),
		.wr_en   (tbl_we),
		.wr_addr (cnt_q[SLOT_W-1:0]),
		.wr_data (id_q),
		.key     (id_q),
		.rd_data (tbl_rd),
		.hit     (tbl_hit)
	);

	// cell map: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[CELL_W'(cell_q)] <= fin_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (map_re) begin
			map_rd_q <= map_mem[CELL_W'(req.data.cell_index)];
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		res_d   = '0;
		res_ld  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				res_d.used_slots = 4'(cnt_q);
				if (acc) begin
					priority if (req.data.req_type == bidt_pkg::REQ_CLEAR) begin
						cnt_d            = '0;
						res_d.used_slots = '0;
						res_ld           = 1'b1;
						state_d          = S_DONE;
					end else if (req.data.req_type == bidt_pkg::REQ_RECORD) begin
						state_d = S_SCAN;
					end else if (map_re) begin
						state_d = S_MAP;
					end else begin
						res_ld  = 1'b1;
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				res_d.used_slots = 4'(cnt_q);
				priority if (scan_hit) begin
					res_d.block_slot   = 3'(fin_slot);
					res_d.slot_land_id = id_q;
					res_d.tile_base    = 13'(32'(fin_slot) * TPB);
					res_ld             = 1'b1;
					state_d            = S_DONE;
				end else if (scan_miss && full) begin
					res_d.overflow = 1'b1;
					res_ld         = 1'b1;
					state_d        = S_DONE;
				end else if (scan_miss) begin
					cnt_d              = cnt_q + 1'b1;
					res_d.block_slot   = 3'(fin_slot);
					res_d.was_new      = 1'b1;
					res_d.slot_land_id = id_q;
					res_d.tile_base    = 13'(32'(fin_slot) * TPB);
					res_d.used_slots   = 4'(cnt_q + 1'b1);
					res_ld             = 1'b1;
					state_d            = S_DONE;
				end else begin
					res_ld = 1'b0;
				end
			end
			S_MAP: begin
				state_d = S_LKID;
			end
			S_LKID: begin
				res_d.block_slot   = 3'(map_rd_q);
				res_d.slot_land_id = tbl_rd;
				res_d.tile_base    = 13'(32'(map_rd_q) * TPB);
				res_d.used_slots   = 4'(cnt_q);
				res_ld             = 1'b1;
				state_d            = S_DONE;
			end
			S_DONE: begin
				if (out_ld) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_ld = (state_q == S_DONE) && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (acc) begin
				idx_q      <= '0;
				cmp_vld_s1 <= 1'b0;
			end else if (state_q == S_SCAN) begin
				cmp_vld_s1 <= scan_issue;
				if (scan_issue) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (out_ld) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cell_q     <= req.data.cell_index;
			id_q       <= req.data.land_id;
			cell_ok_q  <= in_cell_ok;
		end
		if (scan_issue) begin
			cmp_idx_s1 <= idx_q[SLOT_W-1:0];
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (out_ld) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	`BIDT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(MAX_SLOTS))
	`BIDT_IMPLY(a_idx_bound, clk, arst_n, state_q == S_SCAN, idx_q <= cnt_q)
	`BIDT_NEXT(a_append_grows, clk, arst_n, tbl_we, cnt_q == CNT_W'($past(cnt_q) + 1'b1))
	`BIDT_IMPLY(a_ovf_not_new, clk, arst_n, out_vld_q && out_q.overflow, !out_q.was_new)
	`BIDT_IMPLY(a_ovf_full, clk, arst_n, out_vld_q && out_q.overflow, out_q.used_slots == 4'(MAX_SLOTS))

endmodule

### sim/tb_block_id_interning_table.sv
// ----------------------------------------------------------------------------
// Block ID interning table testbench
// Drives clear, record, lookup and unknown requests through the request
// channel, predicts every response word from a local copy of the slot table
// and cell map, and checks each response field by field in arrival order.
// Sender bursts and receiver stalls vary throughout; one long receiver
// hold-off backs the block up, and pauses let every response drain.
// ----------------------------------------------------------------------------
module tb_block_id_interning_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned RANDOM_ITEMS = 1900;
	localparam int unsigned SETTLE_CYCLES = 20;

	typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE} rx_mode_t;

	logic clk;
	logic arst_n;

	bidt_req_if req_ch ();
	bidt_rsp_if rsp_ch ();

	block_id_interning_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// local copy of the block's state
	logic [15:0] slot_ids [bidt_pkg::MAX_SLOTS];
	int unsigned slots_used;
	logic [2:0]  cell_slots [bidt_pkg::MAX_CELLS];
	bit          cell_known [bidt_pkg::MAX_CELLS];
	int unsigned known_cells [$];

	bidt_pkg::rsp_t pending_rsps [$];
	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned burst_left;
	int unsigned hold_request;
	int unsigned hold_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("block_id_interning_table test failed");
		$finish;
	end

	function automatic bidt_pkg::rsp_t intern_predict(bidt_pkg::req_t r);
		bidt_pkg::rsp_t o;
		int   hit;
		o = '0;
		case (r.req_type)
			bidt_pkg::REQ_CLEAR: begin
				slots_used = 0;
			end
			bidt_pkg::REQ_RECORD: begin
				hit = -1;
				for (int i = 0; i < slots_used; i++)
					if (hit < 0 && slot_ids[i] == r.land_id)
						hit = i;
				if (hit < 0 && slots_used >= bidt_pkg::MAX_SLOTS) begin
					// full table, unknown ID: nothing is written
					o.overflow = 1'b1;
				end else begin
					if (hit < 0) begin
						hit = slots_used;
						slot_ids[hit] = r.land_id;
						slots_used++;
						o.was_new = 1'b1;
					end
					if (!cell_known[r.cell_index]) begin
						cell_known[r.cell_index] = 1'b1;
						known_cells.push_back(r.cell_index);
					end
					cell_slots[r.cell_index] = 3'(hit);
					o.block_slot   = 3'(hit);
					o.slot_land_id = r.land_id;
					o.tile_base    = 13'(hit * bidt_pkg::TILES_PER_BLOCK);
				end
			end
			bidt_pkg::REQ_LOOKUP: begin
				// stale slots after a clear still report their old ID
				o.block_slot   = cell_slots[r.cell_index];
				o.slot_land_id = slot_ids[cell_slots[r.cell_index]];
				o.tile_base    = 13'(cell_slots[r.cell_index] * bidt_pkg::TILES_PER_BLOCK);
			end
			default: ;
		endcase
		o.used_slots = 4'(slots_used);
		return o;
	endfunction

	task automatic note_mismatch(string field, int unsigned want, int unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
	endtask

	task automatic check_field(string field, int unsigned want, int unsigned got);
		if (want !== got)
			note_mismatch(field, want, got);
	endtask

	always @(posedge clk) begin
		bidt_pkg::rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_rsps.size() == 0) begin
				note_mismatch("unexpected word, block_slot", 0, rsp_ch.data.block_slot);
			end else begin
				want = pending_rsps.pop_front();
				check_field("block_slot", want.block_slot, rsp_ch.data.block_slot);
				check_field("was_new", want.was_new, rsp_ch.data.was_new);
				check_field("overflow", want.overflow, rsp_ch.data.overflow);
				check_field("slot_land_id", want.slot_land_id, rsp_ch.data.slot_land_id);
				check_field("tile_base", want.tile_base, rsp_ch.data.tile_base);
				check_field("used_slots", want.used_slots, rsp_ch.data.used_slots);
			end
		end
	end

	// receiver: stalls on its own pattern, plus an occasional long hold-off
	initial begin
		rx_mode_t    mode;
		int unsigned mode_left;
		mode = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					RX_OPEN: rsp_ch.ready <= 1'b1;
					RX_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
					default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_word(logic [1:0] kind, logic [9:0] cell_idx, logic [15:0] id);
		bidt_pkg::req_t r;
		int unsigned    gap;
		r.req_type   = kind;
		r.cell_index = cell_idx;
		r.land_id    = id;
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_rsps.push_back(intern_predict(r));
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			// mostly short bursts, now and then a long stretch with no gap
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_for_all_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_rsps.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		logic [15:0] fill_ids [6];
		fill_ids = '{16'h5555, 16'hAAAA, 16'h0001, 16'h8000, 16'h7FFF, 16'h1234};
		send_word(bidt_pkg::REQ_RECORD, 10'd0, 16'h0000);
		send_word(bidt_pkg::REQ_RECORD, 10'd1023, 16'hFFFF);
		send_word(bidt_pkg::REQ_RECORD, 10'd5, 16'h0000);
		send_word(bidt_pkg::REQ_LOOKUP, 10'd0, 16'h0000);
		send_word(bidt_pkg::REQ_LOOKUP, 10'd1023, 16'h0000);
		for (int i = 0; i < 6; i++)
			send_word(bidt_pkg::REQ_RECORD, 10'(6 + i), fill_ids[i]);
		// full table: unknown ID overflows and leaves the cell map alone
		send_word(bidt_pkg::REQ_RECORD, 10'd0, 16'hBEEF);
		send_word(bidt_pkg::REQ_LOOKUP, 10'd0, 16'hFFFF);
		send_word(bidt_pkg::REQ_RECORD, 10'd12, 16'h1234);
		send_word(REQ_UNKNOWN, 10'd1023, 16'hFFFF);
		send_word(bidt_pkg::REQ_CLEAR, 10'd1023, 16'hFFFF);
		send_word(bidt_pkg::REQ_LOOKUP, 10'd1023, 16'h0000);
		send_word(bidt_pkg::REQ_RECORD, 10'd5, 16'hCAFE);
		send_word(bidt_pkg::REQ_LOOKUP, 10'd0, 16'h0000);
		send_word(bidt_pkg::REQ_LOOKUP, 10'd12, 16'h0000);
	endtask

	task automatic test_backpressure();
		hold_request = 400;
		wait (hold_left > 0);
		// keep offering while the receiver is held off
		for (int i = 0; i < 12; i++)
			send_word(bidt_pkg::REQ_RECORD, 10'($urandom_range(0, 1023)),
				16'($urandom_range(0, 15)));
		wait_for_all_results();
		for (int i = 0; i < 4; i++)
			send_word(bidt_pkg::REQ_LOOKUP,
				10'(known_cells[$urandom_range(0, known_cells.size() - 1)]),
				16'($urandom()));
		wait_for_all_results();
	endtask

	task automatic test_random_traffic();
		logic [15:0] id_pool [$];
		int unsigned sent;
		int unsigned episode_left;
		int unsigned roll;
		logic [9:0]  cell_idx;
		logic [15:0] id;
		sent = 0;
		episode_left = 0;
		while (sent < RANDOM_ITEMS) begin
			if (episode_left == 0) begin
				// new episode: fresh ID pool sized around the table depth
				id_pool.delete();
				repeat ($urandom_range(3, 12)) begin
					case ($urandom_range(0, 7))
						0: id_pool.push_back(16'h0000);
						1: id_pool.push_back(16'hFFFF);
						default: id_pool.push_back(16'($urandom()));
					endcase
				end
				episode_left = $urandom_range(30, 120);
				send_word(bidt_pkg::REQ_CLEAR, 10'($urandom()), 16'($urandom()));
				sent++;
			end
			episode_left--;
			roll = $urandom_range(0, 99);
			cell_idx = 10'($urandom());
			id       = 16'($urandom());
			if (known_cells.size() != 0 && $urandom_range(0, 3) == 0)
				cell_idx = 10'(known_cells[$urandom_range(0, known_cells.size() - 1)]);
			if (roll < 3) begin
				send_word(REQ_UNKNOWN, cell_idx, id);
			end else if (roll < 7) begin
				send_word(bidt_pkg::REQ_CLEAR, cell_idx, id);
				sent++;
			end else if (roll < 62) begin
				send_word(bidt_pkg::REQ_RECORD, cell_idx,
					id_pool[$urandom_range(0, id_pool.size() - 1)]);
				sent++;
			end else if (roll < 70 || known_cells.size() == 0) begin
				send_word(bidt_pkg::REQ_RECORD, cell_idx, id);
				sent++;
			end else begin
				cell_idx = 10'(known_cells[$urandom_range(0, known_cells.size() - 1)]);
				send_word(bidt_pkg::REQ_LOOKUP, cell_idx, id);
				sent++;
			end
			if ($urandom_range(0, 299) == 0)
				wait_for_all_results();
		end
	endtask

	initial begin
		mismatches = 0;
		slots_used = 0;
		burst_left = 0;
		hold_request = 0;
		foreach (cell_known[i])
			cell_known[i] = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_for_all_results();
		test_backpressure();
		test_random_traffic();

		wait_for_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatches += pending_rsps.size();
		if (mismatches == 0)
			$display("block_id_interning_table test passed");
		else
			$display("block_id_interning_table test failed");
		$finish;
	end

endmodule
